[rtl/core/lphm_pkg.sv]
// Package: shared types and constants for the linear probe hash map.
package lphm_pkg;

	localparam int KEY_W   = 192;
	localparam int VALUE_W = 32;
	localparam int LIMIT_W = 11;
	localparam int FILL_NUM = 17;
	localparam int FILL_DEN = 20;

	typedef enum logic [1:0] {
		OP_LOOKUP = 2'd0,
		OP_INSERT = 2'd1,
		OP_ADD    = 2'd2,
		OP_DELETE = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLEAR,
		ST_PROBE_RD,
		ST_PROBE_CHK,
		ST_DEL_RD,
		ST_DEL_CHK,
		ST_RI_RD,
		ST_RI_CHK,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		logic               found;
		logic               status;
	} result_t;

	// XOR fold of the key words down to 16 bits
	function automatic logic [15:0] fold_key(input logic [KEY_W-1:0] k);
		logic [31:0] h;
		logic [47:0] au, al, bu, bl;
		au = k[191:144];
		al = k[143:96];
		bu = k[95:48];
		bl = k[47:0];
		h = au[47:16] ^ {16'd0, au[15:0]} ^ {16'd0, al[47:32]} ^ al[31:0]
			^ bu[47:16] ^ {16'd0, bu[15:0]} ^ {16'd0, bl[47:32]} ^ bl[31:0];
		h = h ^ {16'd0, h[31:16]};
		return h[15:0];
	endfunction

endpackage

[rtl/core/lphm_table.sv]
// Slot memory: used bits, keys and values, registered read.
module lphm_table #(
	parameter int AW = 10
) (
	input  logic                           clk,
	input  logic [AW-1:0]                  rd_addr,
	output logic                           rd_used,
	output logic [lphm_pkg::KEY_W-1:0]     rd_key,
	output logic [lphm_pkg::VALUE_W-1:0]   rd_value,
	input  logic                           wr_en,
	input  logic [AW-1:0]                  wr_addr,
	input  logic                           wr_used,
	input  logic [lphm_pkg::KEY_W-1:0]     wr_key,
	input  logic [lphm_pkg::VALUE_W-1:0]   wr_value
);
	localparam int DEPTH = 1 << AW;
	localparam int W = 1 + lphm_pkg::KEY_W + lphm_pkg::VALUE_W;

	logic [W-1:0] mem [DEPTH];
	logic [W-1:0] rd_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= {wr_used, wr_key, wr_value};
		rd_q <= mem[rd_addr];
	end

	assign rd_used  = rd_q[W-1];
	assign rd_key   = rd_q[W-2 -: lphm_pkg::KEY_W];
	assign rd_value = rd_q[lphm_pkg::VALUE_W-1:0];
endmodule

[rtl/core/linear_probe_hash_map.sv]
// Top level: sequencer for the open-addressing hash map with linear probing.
// Usage:
//   Pulse start with kind, key fields (a_*, b_*) and amount while busy is low;
//   the request is taken at that edge and busy rises the next cycle.
//   One result (result_value, found, status) appears for one cycle with done.
//   The receiver cannot stall; the result is only valid while done is high.
// Timing: each slot probed takes a memory read, then a compare; done is high
//   in the cycle after the last compare. busy stays high until after done,
//   so the next request can be taken only once the previous one is through.
//   A delete also walks the following cluster, slot by slot up to and
//   including the first empty one, lifting each entry and re-probing from its
//   home slot. All accesses go through one slot memory with one read and one
//   write port.
// Reset: arst_n clears control state, entry count and fill_limit (to
//   SLOTS*17/20, capped at 2047). After reset a clearing pass writes every slot
//   empty, one per cycle, while busy is high.
// Configuration: cfg_we writes fill_limit from cfg_data; write only while idle.
module linear_probe_hash_map #(
	parameter int SLOTS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [10:0] cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [31:0] a_address,
	input  logic [15:0] a_port,
	input  logic [15:0] a_epoch,
	input  logic [31:0] a_sequence,
	input  logic [31:0] b_address,
	input  logic [15:0] b_port,
	input  logic [15:0] b_epoch,
	input  logic [31:0] b_sequence,
	input  logic signed [31:0] amount,
	output logic        done,
	output logic signed [31:0] result_value,
	output logic        found,
	output logic        status
);
	localparam int AW = $clog2(SLOTS);
	localparam int CW = AW + 1;
	localparam int RESET_RAW = (SLOTS * lphm_pkg::FILL_NUM) / lphm_pkg::FILL_DEN;
	localparam int RESET_LIM = RESET_RAW > 2047 ? 2047 : RESET_RAW;
	localparam int KW = lphm_pkg::KEY_W;
	localparam int VW = lphm_pkg::VALUE_W;

	lphm_pkg::state_t state_q, state_d;

	logic [10:0]   fill_limit_q;
	logic [CW-1:0] count_q, count_d;
	logic [1:0]    kind_q, kind_d;
	logic [KW-1:0] key_q, key_d;
	logic [VW-1:0] amt_q, amt_d;
	logic [AW-1:0] ptr_q, ptr_d;      // probe pointer
	logic [AW-1:0] hole_q, hole_d;    // delete walk pointer
	logic [KW-1:0] mkey_q, mkey_d;    // entry being moved
	logic [VW-1:0] mval_q, mval_d;
	lphm_pkg::result_t res_q, res_d;

	logic          rd_used;
	logic [KW-1:0] rd_key;
	logic [VW-1:0] rd_value;
	logic [AW-1:0] rd_addr;
	logic          wr_en, wr_used;
	logic [AW-1:0] wr_addr;
	logic [KW-1:0] wr_key;
	logic [VW-1:0] wr_value;

	logic [KW-1:0] in_key;
	logic [15:0]   in_fold, rd_fold;
	logic [CW-1:0] limit_now;
	logic          key_hit, m_hit;

	lphm_table #(.AW(AW)) u_table (
		.clk(clk), .rd_addr(rd_addr), .rd_used(rd_used), .rd_key(rd_key),
		.rd_value(rd_value), .wr_en(wr_en), .wr_addr(wr_addr), .wr_used(wr_used),
		.wr_key(wr_key), .wr_value(wr_value)
	);

	assign in_key = {a_address, a_port, a_epoch, a_sequence,
		b_address, b_port, b_epoch, b_sequence};
	assign in_fold = lphm_pkg::fold_key(in_key);
	assign rd_fold = lphm_pkg::fold_key(rd_key);
	assign limit_now = ({1'b0, fill_limit_q} < 12'(SLOTS)) ?
		CW'(fill_limit_q) : CW'(SLOTS - 1);
	assign key_hit = rd_key == key_q;
	assign m_hit   = rd_key == mkey_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= lphm_pkg::ST_CLEAR;
			fill_limit_q <= 11'(RESET_LIM);
			count_q      <= '0;
			ptr_q        <= '0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			ptr_q   <= ptr_d;
			if (cfg_we)
				fill_limit_q <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		kind_q <= kind_d;
		key_q  <= key_d;
		amt_q  <= amt_d;
		hole_q <= hole_d;
		mkey_q <= mkey_d;
		mval_q <= mval_d;
		res_q  <= res_d;
	end

	always_comb begin
		state_d = state_q;
		count_d = count_q;
		kind_d  = kind_q;
		key_d   = key_q;
		amt_d   = amt_q;
		ptr_d   = ptr_q;
		hole_d  = hole_q;
		mkey_d  = mkey_q;
		mval_d  = mval_q;
		res_d   = res_q;
		rd_addr = ptr_q;
		wr_en   = 1'b0;
		wr_addr = ptr_q;
		wr_used = 1'b0;
		wr_key  = key_q;
		wr_value = amt_q;
		case (state_q)
			lphm_pkg::ST_CLEAR: begin
				wr_en = 1'b1;
				ptr_d = ptr_q + 1'b1;
				if (ptr_q == AW'(SLOTS - 1))
					state_d = lphm_pkg::ST_IDLE;
			end
			lphm_pkg::ST_IDLE: begin
				if (start) begin
					kind_d  = kind;
					key_d   = in_key;
					amt_d   = amount;
					ptr_d   = in_fold[AW-1:0];
					state_d = lphm_pkg::ST_PROBE_RD;
				end
			end
			lphm_pkg::ST_PROBE_RD: state_d = lphm_pkg::ST_PROBE_CHK;
			lphm_pkg::ST_PROBE_CHK: begin
				res_d = '0;
				state_d = lphm_pkg::ST_DONE;
				if (rd_used && !key_hit) begin
					ptr_d   = ptr_q + 1'b1;
					state_d = lphm_pkg::ST_PROBE_RD;
				end else if (rd_used) begin
					res_d.found = 1'b1;
					case (lphm_pkg::op_t'(kind_q))
						lphm_pkg::OP_LOOKUP: res_d.value = rd_value;
						lphm_pkg::OP_INSERT, lphm_pkg::OP_ADD: begin
							wr_en    = 1'b1;
							wr_used  = 1'b1;
							wr_value = (kind_q == lphm_pkg::OP_ADD) ?
								rd_value + amt_q : amt_q;
							res_d.value = wr_value;
						end
						lphm_pkg::OP_DELETE: begin
							wr_en = 1'b1;
							if (count_q != '0)
								count_d = count_q - 1'b1;
							hole_d  = ptr_q + 1'b1;
							state_d = lphm_pkg::ST_DEL_RD;
						end
						default: ;
					endcase
				end else if (kind_q == lphm_pkg::OP_INSERT || kind_q == lphm_pkg::OP_ADD) begin
					if (count_q < limit_now) begin
						wr_en   = 1'b1;
						wr_used = 1'b1;
						count_d = count_q + 1'b1;
						res_d.value = amt_q;
					end else
						res_d.status = 1'b1;
				end
			end
			lphm_pkg::ST_DEL_RD: begin
				rd_addr = hole_q;
				state_d = lphm_pkg::ST_DEL_CHK;
			end
			lphm_pkg::ST_DEL_CHK: begin
				// cluster ends at first empty slot; else lift entry and re-probe
				if (!rd_used)
					state_d = lphm_pkg::ST_DONE;
				else begin
					mkey_d  = rd_key;
					mval_d  = rd_value;
					wr_en   = 1'b1;
					wr_addr = hole_q;
					ptr_d   = rd_fold[AW-1:0];
					state_d = lphm_pkg::ST_RI_RD;
				end
			end
			lphm_pkg::ST_RI_RD: state_d = lphm_pkg::ST_RI_CHK;
			lphm_pkg::ST_RI_CHK: begin
				if (rd_used && !m_hit)
					ptr_d = ptr_q + 1'b1;
				else begin
					if (!rd_used) begin
						wr_en    = 1'b1;
						wr_used  = 1'b1;
						wr_key   = mkey_q;
						wr_value = mval_q;
					end
					hole_d = hole_q + 1'b1;
				end
				state_d = (rd_used && !m_hit) ? lphm_pkg::ST_RI_RD : lphm_pkg::ST_DEL_RD;
			end
			lphm_pkg::ST_DONE: state_d = lphm_pkg::ST_IDLE;
			default: state_d = lphm_pkg::ST_IDLE;
		endcase
	end

	assign busy = state_q != lphm_pkg::ST_IDLE;
	assign done = state_q == lphm_pkg::ST_DONE;
	assign result_value = res_q.value;
	assign found  = res_q.found;
	assign status = res_q.status;
endmodule

[rtl/core/lphm_checker.sv]
// Port-level checker for the hash map, bound to the top level.
module lphm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic        found,
	input logic        status,
	input logic signed [31:0] result_value
);
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy) else $error("done while not busy");
	a_take: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("request not taken");
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("done longer than one cycle");
	a_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status) |-> (!found && result_value == 0))
		else $error("refused insert with data");
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy) else $error("busy after done");
endmodule

bind linear_probe_hash_map lphm_checker u_lphm_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.found(found), .status(status), .result_value(result_value)
);
